[hw/rtl/pvte_pkg.sv]
// pvte_pkg: shared types and constants for the polygon vertex transform engine.
// No dependencies.
package pvte_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_XLATE   = 3'd2,
    CMD_ROT_ORG = 3'd3,
    CMD_ROT_CEN = 3'd4,
    CMD_SCALE   = 3'd5,
    CMD_QUERY   = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam int TRIG_BITS = 14;

  // memory port request from the sequencer
  typedef struct packed {
    logic        we;
    logic [31:0] wx;
    logic [31:0] wy;
  } mem_wr_t;

endpackage

[hw/rtl/polygon_vertex_transform_engine.sv]
// Polygon vertex transform engine, top level.
// Usage: assert start with a command while busy is low; the item is taken
// at that edge and busy rises until the single result is done.
// The result shows on out_* for exactly one cycle, marked by out_valid;
// the receiver cannot stall it, so it must take it then.
// Commands: write and read touch one vertex. Translate, rotate and scale
// walk the n vertices through the vertex memory with a read, a multiply
// (skipped for translate) and a write back per vertex.
// Rotate about centroid and query first sum all vertices and run a
// bit-serial divider by n twice. Query then walks the edges, reading each
// vertex and the next one and multiplying, and finishes the area.
// The memory walk and the divider set the run time; busy drops in the
// cycle the result shows.
// cfg_we writes vertex_count; the user must do so only while the block is idle, as the block has no guard for it.
// Reset clears control state and sets vertex_count to 3; vertex contents
// are undefined until written and take no clearing pass.
module polygon_vertex_transform_engine #(
  parameter int MAX_VERTICES = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [5:0]  in_index,
  input  logic signed [31:0] in_x_value,
  input  logic signed [31:0] in_y_value,
  input  logic signed [15:0] in_cos_value,
  input  logic signed [15:0] in_sin_value,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output logic        out_valid,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic [62:0] out_area_out,
  output logic [1:0]  out_status
);
  localparam int AW = $clog2(MAX_VERTICES);

  logic [6:0]       vcount_r;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [31:0]      rd_x, rd_y;
  pvte_pkg::mem_wr_t wr;

  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 7'd3;
    else if (cfg_we) vcount_r <= cfg_wdata;
  end

  pvte_vmem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_mem (
    .clk(clk), .rd_addr(rd_addr), .rd_x(rd_x), .rd_y(rd_y),
    .wr_addr(wr_addr), .wr(wr)
  );

  pvte_seq #(.MAX_VERTICES(MAX_VERTICES), .FRAC_BITS(FRAC_BITS), .AW(AW)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_index(in_index), .in_x_value(in_x_value),
    .in_y_value(in_y_value), .in_cos_value(in_cos_value),
    .in_sin_value(in_sin_value), .vcount(vcount_r),
    .rd_addr(rd_addr), .rd_x(rd_x), .rd_y(rd_y),
    .wr_addr(wr_addr), .wr(wr),
    .out_valid(out_valid), .out_x_out(out_x_out), .out_y_out(out_y_out),
    .out_area_out(out_area_out), .out_status(out_status)
  );
endmodule

[hw/rtl/pvte_vmem.sv]
// pvte_vmem: vertex store, x and y words side by side, one write and one
// registered read port. Depends on pvte_pkg.
module pvte_vmem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic [AW-1:0]    rd_addr,
  output logic [31:0]      rd_x,
  output logic [31:0]      rd_y,
  input  logic [AW-1:0]    wr_addr,
  input  pvte_pkg::mem_wr_t wr
);
  logic [63:0] mem [DEPTH];
  logic [63:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr_addr] <= {wr.wx, wr.wy};
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_x = rd_r[63:32];
  assign rd_y = rd_r[31:0];
endmodule

[hw/rtl/pvte_divider.sv]
// pvte_divider: restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module pvte_divider #(
  parameter int NW = 40,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;

  assign trial = {rem_r[DW-1:0], q_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= trial - {1'b0, den_r};
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo = q_r;
endmodule

[hw/rtl/pvte_seq.sv]
// pvte_seq: command sequencer; walks the vertex store, does the
// read-modify-write passes, centroid sums and shoelace accumulation.
// Depends on pvte_pkg, pvte_divider.
module pvte_seq #(
  parameter int MAX_VERTICES = 64,
  parameter int FRAC_BITS    = 16,
  parameter int AW           = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_cmd,
  input  logic [5:0]        in_index,
  input  logic [31:0]       in_x_value,
  input  logic [31:0]       in_y_value,
  input  logic [15:0]       in_cos_value,
  input  logic [15:0]       in_sin_value,
  input  logic [6:0]        vcount,
  output logic [AW-1:0]     rd_addr,
  input  logic [31:0]       rd_x,
  input  logic [31:0]       rd_y,
  output logic [AW-1:0]     wr_addr,
  output pvte_pkg::mem_wr_t wr,
  output logic              out_valid,
  output logic [31:0]       out_x_out,
  output logic [31:0]       out_y_out,
  output logic [62:0]       out_area_out,
  output logic [1:0]        out_status
);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int SW  = 32 + NW + 1;   // signed sum width
  localparam int AAW = 66 + NW;       // area accumulator width
  localparam int SH  = FRAC_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SUM, S_DIVX, S_DIVY, S_MAP, S_MUL, S_WB, S_AREA, S_AFIN, S_DONE
  } state_t;

  state_t         state_r;
  logic [2:0]     cmd_r;
  logic [5:0]     idx_r;
  logic signed [31:0] xv_r, yv_r;
  logic signed [15:0] c_r, s_r;
  logic [NW-1:0]  n_r;
  logic [NW-1:0]  i_r;      // issue index
  logic [NW-1:0]  j_r;      // data index of rd data
  logic           rv_r;     // read data valid
  logic signed [SW-1:0] sx_r, sy_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [31:0] x0_r, y0_r, px_r, py_r;
  logic signed [33:0] dx_r, dy_r;
  logic signed [63:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [AAW-1:0] acc_r;
  logic [1:0]     ph_r;
  logic           sel_y_r;
  logic [31:0]    ox_r, oy_r;
  logic [62:0]    oa_r;
  logic [1:0]     ost_r;
  logic           ov_r;

  // divider
  logic           dv_start;
  logic [SW-1:0]  dv_num;
  logic           dv_done;
  logic [SW-1:0]  dv_quo;
  pvte_divider #(.NW(SW), .DW(NW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(n_r),
    .done(dv_done), .quo(dv_quo)
  );

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  logic [NW-1:0] n_used;
  always_comb begin
    if (vcount < 7'd3) n_used = NW'(3);
    else if ({{(NW > 7 ? NW - 7 : 0){1'b0}}, vcount} > (NW > 7 ? NW : 7)'(MAX_VERTICES))
      n_used = NW'(MAX_VERTICES);
    else n_used = NW'(vcount);
  end

  logic signed [SW-1:0] sel_sum;
  logic [SW-1:0] abs_sum;
  assign sel_sum = sel_y_r ? sy_r : sx_r;
  assign abs_sum = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);
  assign dv_num  = abs_sum + SW'(n_r >> 1);

  logic signed [SW-1:0] qs;
  assign qs = sel_sum[SW-1] ? -$signed(dv_quo) : $signed(dv_quo);

  // rounding helpers
  logic signed [63:0] rx_sum, ry_sum, rx_rnd, ry_rnd, nx, ny;
  logic signed [63:0] pxe, pye;
  assign pxe = 64'(cx_r);
  assign pye = 64'(cy_r);

  logic [AAW-1:0] amag, around;
  logic [AAW-1:0] ashift;

  assign amag   = acc_r[AAW-1] ? AAW'(-acc_r) : AAW'(acc_r);
  assign around = amag + (AAW'(1) << FRAC_BITS);
  assign ashift = around >> SH;

  always_comb begin
    rx_sum = p1_r - p2_r;
    ry_sum = p3_r + p4_r;
    if (cmd_r == 3'(pvte_pkg::CMD_SCALE)) begin
      rx_rnd = (rx_sum + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      ry_rnd = (p3_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      nx = rx_rnd;
      ny = ry_rnd;
    end else begin
      rx_rnd = (rx_sum + (64'sd1 <<< (pvte_pkg::TRIG_BITS - 1))) >>> pvte_pkg::TRIG_BITS;
      ry_rnd = (ry_sum + (64'sd1 <<< (pvte_pkg::TRIG_BITS - 1))) >>> pvte_pkg::TRIG_BITS;
      nx = pxe + rx_rnd;
      ny = pye + ry_rnd;
    end
  end

  assign busy = (state_r != S_IDLE);

  // area walk: second read of each pair goes to the next vertex
  logic [NW-1:0] inext;
  assign inext = (i_r == n_r - 1'b1) ? '0 : i_r + 1'b1;
  logic [AW-1:0] area_addr;
  assign area_addr = (ph_r == 2'd1) ? AW'(inext) : AW'(i_r);

  always_comb begin
    rd_addr = AW'(i_r);
    if (state_r == S_IDLE) rd_addr = AW'(in_index);
    else if (state_r == S_RD) rd_addr = AW'(idx_r);
    else if (state_r == S_AREA) rd_addr = area_addr;
    wr_addr = AW'(j_r);
    wr.we = 1'b0;
    wr.wx = '0;
    wr.wy = '0;
    dv_start = 1'b0;
    if (state_r == S_IDLE && start && in_cmd == 3'(pvte_pkg::CMD_WRITE)
        && {1'b0, in_index} < 7'(n_used)) begin
      wr.we = 1'b1;
      wr.wx = in_x_value;
      wr.wy = in_y_value;
      wr_addr = AW'(in_index);
    end
    if (state_r == S_WB) begin
      wr.we = 1'b1;
      if (cmd_r == 3'(pvte_pkg::CMD_XLATE)) begin
        wr.wx = sat32(64'(x0_r) + 64'(xv_r));
        wr.wy = sat32(64'(y0_r) + 64'(yv_r));
      end else begin
        wr.wx = sat32(nx);
        wr.wy = sat32(ny);
      end
    end
    if ((state_r == S_DIVX || state_r == S_DIVY) && ph_r == 2'd0) dv_start = 1'b1;
  end

  // each divide starts on the first cycle of DIVX / DIVY, once the sums are final
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          cmd_r <= in_cmd; idx_r <= in_index;
          xv_r <= in_x_value; yv_r <= in_y_value;
          c_r <= in_cos_value; s_r <= in_sin_value;
          n_r <= n_used;
          i_r <= '0; j_r <= '0; rv_r <= 1'b0;
          sx_r <= '0; sy_r <= '0; acc_r <= '0;
          cx_r <= '0; cy_r <= '0; sel_y_r <= 1'b0; ph_r <= '0;
          ox_r <= '0; oy_r <= '0; oa_r <= '0; ost_r <= pvte_pkg::ST_OK;
          unique case (in_cmd)
            3'(pvte_pkg::CMD_WRITE): begin
              if ({1'b0, in_index} >= 7'(n_used)) ost_r <= pvte_pkg::ST_RANGE;
              state_r <= S_DONE;
            end
            3'(pvte_pkg::CMD_READ): begin
              if ({1'b0, in_index} >= 7'(n_used)) begin
                ost_r <= pvte_pkg::ST_RANGE;
                state_r <= S_DONE;
              end else state_r <= S_RD;
            end
            3'(pvte_pkg::CMD_XLATE), 3'(pvte_pkg::CMD_ROT_ORG),
            3'(pvte_pkg::CMD_SCALE): state_r <= S_MAP;
            3'(pvte_pkg::CMD_ROT_CEN), 3'(pvte_pkg::CMD_QUERY): state_r <= S_SUM;
            default: state_r <= S_DONE;
          endcase
        end
        S_RD: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 2'd1) begin
            ox_r <= rd_x; oy_r <= rd_y;
            state_r <= S_DONE;
          end
        end
        S_SUM: begin
          // issue reads 0..n-1; data arrives in the next cycle
          rv_r <= (i_r < n_r);
          if (i_r < n_r) i_r <= i_r + 1'b1;
          if (rv_r) begin
            sx_r <= sx_r + SW'($signed(rd_x));
            sy_r <= sy_r + SW'($signed(rd_y));
            j_r  <= j_r + 1'b1;
            if (j_r == n_r - 1'b1) begin
              state_r <= S_DIVX;
              sel_y_r <= 1'b0;
            end
          end
        end
        S_DIVX: begin
          if (dv_done) begin
            cx_r <= 34'(qs);
            sel_y_r <= 1'b1;
            ph_r <= '0;
            state_r <= S_DIVY;
          end else if (ph_r == 2'd0) ph_r <= 2'd1;
        end
        S_DIVY: begin
          if (dv_done) begin
            cy_r <= 34'(qs);
            i_r <= '0; j_r <= '0; rv_r <= 1'b0; ph_r <= '0;
            if (cmd_r == 3'(pvte_pkg::CMD_QUERY)) begin
              ox_r <= cx_r[31:0]; oy_r <= qs[31:0];
              state_r <= S_AREA;
            end else state_r <= S_MAP;
          end else if (ph_r == 2'd0) ph_r <= 2'd1;
        end
        S_MAP: begin
          // rd issued at i_r this cycle (addr i_r); data is taken in the next cycle
          if (ph_r == 2'd1) begin
            ph_r <= '0;
            x0_r <= rd_x; y0_r <= rd_y;
            j_r  <= i_r;
            dx_r <= 34'($signed(rd_x)) - cx_r;
            dy_r <= 34'($signed(rd_y)) - cy_r;
            state_r <= (cmd_r == 3'(pvte_pkg::CMD_XLATE)) ? S_WB : S_MUL;
          end else ph_r <= ph_r + 1'b1;
        end
        S_MUL: begin
          if (cmd_r == 3'(pvte_pkg::CMD_SCALE)) begin
            p1_r <= 64'(x0_r) * 64'(xv_r);
            p2_r <= '0;
            p3_r <= 64'(y0_r) * 64'(yv_r);
            p4_r <= '0;
          end else begin
            p1_r <= 64'(c_r) * 64'(dx_r);
            p2_r <= 64'(s_r) * 64'(dy_r);
            p3_r <= 64'(s_r) * 64'(dx_r);
            p4_r <= 64'(c_r) * 64'(dy_r);
          end
          state_r <= S_WB;
        end
        S_WB: begin
          if (i_r == n_r - 1'b1) state_r <= S_DONE;
          else begin
            i_r <= i_r + 1'b1;
            state_r <= S_MAP;
          end
        end
        S_AREA: begin
          // phase 0: read i, 1: read j(=i+1 wrap) latch xi,yi, 2: latch xj,yj, 3: mul
          ph_r <= ph_r + 1'b1;
          unique case (ph_r)
            2'd0: ;
            2'd1: begin x0_r <= rd_x; y0_r <= rd_y; end
            2'd2: begin
              px_r <= rd_x; py_r <= rd_y;
            end
            default: begin
              acc_r <= acc_r + AAW'(64'(x0_r) * 64'(py_r))
                             - AAW'(64'(px_r) * 64'(y0_r));
              if (i_r == n_r - 1'b1) state_r <= S_AFIN;
              else i_r <= i_r + 1'b1;
            end
          endcase
        end
        S_AFIN: begin
          if ((ashift >> 63) != '0) begin
            oa_r <= 63'h7fff_ffff_ffff_ffff;
            ost_r <= pvte_pkg::ST_SAT;
          end else oa_r <= ashift[62:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          ov_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = ov_r;
  assign out_x_out    = ox_r;
  assign out_y_out    = oy_r;
  assign out_area_out = oa_r;
  assign out_status   = ost_r;
endmodule
